// ===== hw/rtl/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the ARP responder with IP-to-MAC cache.
// ----------------------------------------------------------------------------
package arpc_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUBNET_MASK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GATEWAY_IP  = 2'd3;

  // ARP message checks
  localparam logic [15:0] MSG_BYTES    = 16'd28;
  localparam logic [15:0] HW_ETHERNET  = 16'h0001;
  localparam logic [15:0] PROTO_IPV4   = 16'h0800;
  localparam logic [15:0] OPER_REQUEST = 16'd1;
  localparam logic [15:0] OPER_REPLY   = 16'd2;

  typedef enum logic [2:0] {
    ACT_DROP    = 3'd0,
    ACT_REPLY   = 3'd1,
    ACT_REQUEST = 3'd2,
    ACT_HIT     = 3'd3,
    ACT_LEARNED = 3'd4,
    ACT_CACHED  = 3'd5
  } action_e;

  // What a word turns into once its fields are checked
  typedef enum logic [1:0] {
    KIND_DROP    = 2'd0,
    KIND_REPLY   = 2'd1,
    KIND_LEARN   = 2'd2,
    KIND_RESOLVE = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_WRITE = 4'b1000
  } state_e;

  typedef struct packed {
    logic        mode;
    logic [15:0] frame_len;
    logic [15:0] hw_type;
    logic [15:0] ptype;
    logic [15:0] op_code;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [31:0] dest_ip;
  } in_word_t;

  typedef struct packed {
    action_e     action;
    logic [47:0] out_target_mac;
    logic [31:0] out_target_ip;
    logic [47:0] resolved_mac;
    logic [31:0] next_hop_ip;
  } out_word_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic commit;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic need_scan;
    logic hit;
    logic miss;
  } sts_t;

endpackage

// ===== hw/rtl/arpc_in_if.sv =====
// ----------------------------------------------------------------------------
// arpc_in_if
// Valid/ready channel carrying one ARP input word.
// ----------------------------------------------------------------------------
interface arpc_in_if;
  import arpc_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ===== hw/rtl/arpc_out_if.sv =====
// ----------------------------------------------------------------------------
// arpc_out_if
// Valid/ready channel carrying one ARP result word.
// ----------------------------------------------------------------------------
interface arpc_out_if;
  import arpc_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ===== hw/rtl/arpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// arpc_ctrl
// Sequencer: accept a word, run the cache scan if needed, load the result.
// ----------------------------------------------------------------------------
module arpc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  arpc_pkg::sts_t  sts_i,
  output arpc_pkg::cmd_t  cmd_o
);
  import arpc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.load    = in_valid_i && (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = sts_i.need_scan ? ST_SCAN : ST_WRITE;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.hit || sts_i.miss) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.commit = slot_free;
        if (slot_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hw/rtl/arpc_datapath.sv =====
// ----------------------------------------------------------------------------
// arpc_datapath
// Config registers, word checks, cache memory with scan and result register.
// ----------------------------------------------------------------------------
module arpc_datapath #(
  parameter int unsigned CACHE_ENTRIES = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [arpc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  arpc_pkg::in_word_t                  in_word_i,
  output arpc_pkg::out_word_t                 out_word_o,
  input  arpc_pkg::cmd_t                      cmd_i,
  output arpc_pkg::sts_t                      sts_o
);
  import arpc_pkg::*;

  localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(CACHE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(CACHE_ENTRIES);

  // Configuration
  logic [31:0] own_ip_q, subnet_mask_q, gateway_ip_q;

  // Item held while it is worked on
  kind_e       kind_q, kind_d;
  logic [31:0] key_q, key_d;
  logic [47:0] mac_q;
  logic        hit_q;
  logic [47:0] hit_mac_q;

  // Cache
  logic [31:0]              mem_ip  [CACHE_ENTRIES];
  logic [47:0]              mem_mac [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] valid_q;
  logic [IDX_W-1:0]         fill_q;

  // Scan
  logic [CNT_W-1:0] rd_idx_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             cmp_pend_q;
  logic [31:0]      rd_ip_q;
  logic [47:0]      rd_mac_q;
  logic             issue, match, store;

  logic [31:0] hop_ip;
  logic        frame_ok;
  out_word_t   res_d, res_q;

  // Configuration writes; own MAC only goes into frame assembly, so drop it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q      <= '0;
      subnet_mask_q <= '0;
      gateway_ip_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OWN_IP:      own_ip_q      <= cfg_data_i[31:0];
        REG_OWN_MAC:     ;
        REG_SUBNET_MASK: subnet_mask_q <= cfg_data_i[31:0];
        REG_GATEWAY_IP:  gateway_ip_q  <= cfg_data_i[31:0];
        default:         ;
      endcase
    end
  end

  // Classify the incoming word
  always_comb begin
    hop_ip   = (((in_word_i.dest_ip ^ own_ip_q) & subnet_mask_q) == '0) ?
               in_word_i.dest_ip : gateway_ip_q;
    frame_ok = (in_word_i.frame_len >= MSG_BYTES) &&
               (in_word_i.hw_type == HW_ETHERNET) &&
               (in_word_i.ptype == PROTO_IPV4) &&
               (in_word_i.target_ip == own_ip_q);
    kind_d = KIND_DROP;
    key_d  = in_word_i.sender_ip;
    if (in_word_i.mode) begin
      kind_d = KIND_RESOLVE;
      key_d  = hop_ip;
    end else if (frame_ok && (in_word_i.op_code == OPER_REQUEST)) begin
      kind_d = KIND_REPLY;
    end else if (frame_ok && (in_word_i.op_code == OPER_REPLY)) begin
      kind_d = KIND_LEARN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_DROP;
    end else if (cmd_i.load) begin
      kind_q <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= key_d;
      mac_q <= in_word_i.sender_mac;
    end
  end

  // Scan: one entry read per cycle, compared the cycle after
  assign issue = cmd_i.scan_step && (rd_idx_q != CNT_END);
  assign match = cmp_pend_q && valid_q[cmp_idx_q] && (rd_ip_q == key_q);
  assign store = cmd_i.commit && (kind_q == KIND_LEARN) && !hit_q;

  assign sts_o.need_scan = (kind_q == KIND_LEARN) || (kind_q == KIND_RESOLVE);
  assign sts_o.hit       = match;
  assign sts_o.miss      = !cmp_pend_q && (rd_idx_q == CNT_END);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q   <= '0;
      cmp_idx_q  <= '0;
      cmp_pend_q <= 1'b0;
      hit_q      <= 1'b0;
      valid_q    <= '0;
      fill_q     <= '0;
    end else begin
      if (cmd_i.load) begin
        rd_idx_q   <= '0;
        cmp_pend_q <= 1'b0;
        hit_q      <= 1'b0;
      end else if (cmd_i.scan_step) begin
        cmp_pend_q <= issue;
        if (issue) begin
          rd_idx_q  <= rd_idx_q + CNT_W'(1);
          cmp_idx_q <= rd_idx_q[IDX_W-1:0];
        end
        if (match) hit_q <= 1'b1;
      end
      if (store) begin
        valid_q[fill_q] <= 1'b1;
        fill_q          <= (fill_q == LAST_IDX) ? '0 : fill_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && match) hit_mac_q <= rd_mac_q;
  end

  // Cache memory: write on learn, registered read during scan
  always_ff @(posedge clk_i) begin
    if (store) begin
      mem_ip[fill_q]  <= key_q;
      mem_mac[fill_q] <= mac_q;
    end
    if (issue) begin
      rd_ip_q  <= mem_ip[rd_idx_q[IDX_W-1:0]];
      rd_mac_q <= mem_mac[rd_idx_q[IDX_W-1:0]];
    end
  end

  // Result word
  always_comb begin
    res_d        = '0;
    res_d.action = ACT_DROP;
    unique case (kind_q)
      KIND_DROP: ;
      KIND_REPLY: begin
        res_d.action         = ACT_REPLY;
        res_d.out_target_mac = mac_q;
        res_d.out_target_ip  = key_q;
      end
      KIND_LEARN: begin
        res_d.action = hit_q ? ACT_CACHED : ACT_LEARNED;
      end
      KIND_RESOLVE: begin
        res_d.next_hop_ip = key_q;
        if (hit_q) begin
          res_d.action       = ACT_HIT;
          res_d.resolved_mac = hit_mac_q;
        end else begin
          res_d.action        = ACT_REQUEST;
          res_d.out_target_ip = key_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) res_q <= res_d;
  end

  assign out_word_o = res_q;

endmodule

// ===== hw/rtl/arp_responder_cache.sv =====
// ----------------------------------------------------------------------------
// arp_responder_cache
// ARP engine with an associative IP-to-MAC cache refilled round-robin.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : one word per ARP event. mode 0 carries the parsed fields of a
//            received ARP message; mode 1 carries an outgoing destination IP.
//   out_if : one result word per input word (drop, reply, request, hit,
//            learned, already cached), fields that do not apply read zero.
//   cfg    : write own IP, own MAC, subnet mask and gateway IP while idle.
// Flow (N = CACHE_ENTRIES, k = index of the matching entry), one word at a time:
//   drop / reply      : no cache scan; the result is written after the check.
//   cache hit         : the scan stops at the match in entry k, then writes.
//   miss / new learn  : the scan compares all N entries, then writes.
//   The cache is one memory with one read port; the lookup walks it one
//   entry per cycle from entry 0 and stops at the first valid match.
// Reset clears the config registers, the valid bits and the fill pointer;
//   the cache contents need no clearing pass.
// A stalled result sits in the output register; the next input word is still
//   taken and worked on, and waits for the output slot only at the very end.
// ----------------------------------------------------------------------------
module arp_responder_cache #(
  parameter int unsigned CACHE_ENTRIES = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  arpc_in_if.sink                         in_if,
  arpc_out_if.source                      out_if
);
  import arpc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer: hold one word at a time, advance through check, scan if needed, write
  arpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: config, classification, cache and result register
  arpc_datapath #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_word_i  (in_if.payload),
    .out_word_o (out_if.payload),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

// ===== hw/rtl/arpc_checker.sv =====
// ----------------------------------------------------------------------------
// arpc_checker
// Port-level checks on the ARP responder, bound to the top level.
// ----------------------------------------------------------------------------
module arpc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input arpc_pkg::out_word_t out_word_i
);
  import arpc_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i))
    else $error("result changed while stalled");

  // One word in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while busy");

  a_action_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_word_i.action <= ACT_CACHED)
    else $error("undefined action code");

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_word_i.action == ACT_DROP) |->
      (out_word_i.out_target_mac == '0) && (out_word_i.out_target_ip == '0) &&
      (out_word_i.resolved_mac == '0) && (out_word_i.next_hop_ip == '0))
    else $error("drop result carries data");

  a_request_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_word_i.action == ACT_REQUEST) |->
      (out_word_i.out_target_ip == out_word_i.next_hop_ip) &&
      (out_word_i.out_target_mac == '0) && (out_word_i.resolved_mac == '0))
    else $error("request result fields inconsistent");

endmodule

bind arp_responder_cache arpc_checker u_arpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_word_i  (out_if.payload)
);

// ===== tb/arp_responder_cache_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arp_responder_cache_test
// Self-checking bench for the ARP responder and its IP-to-MAC cache. A queue
// of words feeds a clocked driver. A clocked monitor compares every result
// word, field by field, against a cycle-free predictor that keeps its own
// cache and register copies. The words cover directed corner cases, learning
// traffic with random content and noise, under several register settings.
// ----------------------------------------------------------------------------
module arp_responder_cache_test;
  import arpc_pkg::*;

  localparam int unsigned NUM_ENTRIES    = 8;
  localparam int unsigned POOL_SIZE      = 12;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned CYCLE_LIMIT    = 250000;
  localparam int unsigned MAX_PRINTED    = 40;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  // Register write port
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  arpc_in_if  in_bus ();
  arpc_out_if out_bus ();

  arp_responder_cache #(
    .CACHE_ENTRIES (NUM_ENTRIES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (in_bus),
    .out_if     (out_bus)
  );

  // Words waiting for the driver, and results the block still owes us
  in_word_t  pending_words[$];
  out_word_t owed_results[$];

  // Shadow copy of the registers
  logic [31:0] cfg_own_ip;
  logic [47:0] cfg_own_mac;
  logic [31:0] cfg_mask;
  logic [31:0] cfg_gateway;

  // Shadow copy of the cache
  logic [31:0] shadow_ip  [NUM_ENTRIES];
  logic [47:0] shadow_mac [NUM_ENTRIES];
  logic        shadow_vld [NUM_ENTRIES];
  int unsigned fill_slot;

  // Addresses that the learning traffic draws from, so that hits happen
  logic [31:0] ip_pool [POOL_SIZE];

  // Run control
  logic        idle_en;
  logic        hold_armed;
  logic        long_hold = 1'b0;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned cycle_count = 0;
  int unsigned words_sent  = 0;
  int unsigned error_count = 0;
  int unsigned setting_count = 0;
  int unsigned action_count [6];
  out_word_t   want;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Lowest valid entry holding ip, or -1
  function automatic int find_entry(logic [31:0] ip);
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      if (shadow_vld[k] && shadow_ip[k] == ip) return k;
    end
    return -1;
  endfunction

  // Work out the result of one accepted word and advance the shadow cache
  function automatic out_word_t predict_result(in_word_t w);
    out_word_t r;
    int        slot;
    logic      for_us;
    r        = '0;
    r.action = ACT_DROP;
    if (!w.mode) begin
      for_us = (w.frame_len >= MSG_BYTES) && (w.hw_type == HW_ETHERNET) &&
               (w.ptype == PROTO_IPV4) && (w.target_ip == cfg_own_ip);
      if (for_us && w.op_code == OPER_REQUEST) begin
        r.action         = ACT_REPLY;
        r.out_target_mac = w.sender_mac;
        r.out_target_ip  = w.sender_ip;
      end else if (for_us && w.op_code == OPER_REPLY) begin
        if (find_entry(w.sender_ip) >= 0) begin
          r.action = ACT_CACHED;
        end else begin
          // Overwrite the round-robin slot and advance it
          shadow_ip[fill_slot]  = w.sender_ip;
          shadow_mac[fill_slot] = w.sender_mac;
          shadow_vld[fill_slot] = 1'b1;
          fill_slot             = (fill_slot + 1) % NUM_ENTRIES;
          r.action              = ACT_LEARNED;
        end
      end
    end else begin
      // Local destinations go direct, everything else through the gateway
      r.next_hop_ip = (((w.dest_ip ^ cfg_own_ip) & cfg_mask) == '0) ? w.dest_ip : cfg_gateway;
      slot = find_entry(r.next_hop_ip);
      if (slot >= 0) begin
        r.action       = ACT_HIT;
        r.resolved_mac = shadow_mac[slot];
      end else begin
        r.action        = ACT_REQUEST;
        r.out_target_ip = r.next_hop_ip;
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Word builders
  // --------------------------------------------------------------------------

  // Received ARP message; the resolve field carries junk
  function automatic in_word_t arp_message(logic [15:0] len, logic [15:0] hw,
                                           logic [15:0] proto, logic [15:0] op,
                                           logic [47:0] smac, logic [31:0] sip,
                                           logic [31:0] tip);
    in_word_t w;
    w.mode       = 1'b0;
    w.frame_len  = len;
    w.hw_type    = hw;
    w.ptype      = proto;
    w.op_code    = op;
    w.sender_mac = smac;
    w.sender_ip  = sip;
    w.target_ip  = tip;
    w.dest_ip    = 32'($urandom);
    return w;
  endfunction

  // Outgoing destination; the ARP fields carry junk
  function automatic in_word_t resolve_request(logic [31:0] dest);
    in_word_t w;
    w = arp_message(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    {16'($urandom), 32'($urandom)}, 32'($urandom), 32'($urandom));
    w.mode    = 1'b1;
    w.dest_ip = dest;
    return w;
  endfunction

  // Mostly well-formed traffic around the pool, some broken, some pure noise
  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned pick;
    logic [15:0] op;
    pick = $urandom_range(0, 99);
    op   = ($urandom_range(0, 1) != 0) ? OPER_REPLY : OPER_REQUEST;
    w = arp_message(MSG_BYTES + 16'($urandom_range(0, 40)), HW_ETHERNET, PROTO_IPV4,
                    op, {16'($urandom), 32'($urandom)},
                    ip_pool[$urandom_range(0, POOL_SIZE - 1)], cfg_own_ip);
    if (pick < 30) begin
      w.op_code = OPER_REPLY;
    end else if (pick < 45) begin
      w.op_code = OPER_REQUEST;
      if ($urandom_range(0, 1) != 0) w.sender_ip = 32'($urandom);
    end else if (pick < 70) begin
      w = resolve_request(($urandom_range(0, 1) != 0) ?
                          ip_pool[$urandom_range(0, POOL_SIZE - 1)] : 32'($urandom));
    end else if (pick < 85) begin
      // Break exactly one of the acceptance checks
      case ($urandom_range(0, 4))
        0: w.frame_len  = 16'($urandom_range(0, 27));
        1: w.hw_type    = HW_ETHERNET ^ 16'($urandom_range(1, 65535));
        2: w.ptype      = PROTO_IPV4 ^ 16'($urandom_range(1, 65535));
        3: w.target_ip  = cfg_own_ip ^ 32'($urandom_range(1, 32'hFFFF_FFFF));
        default: w.op_code = ($urandom_range(0, 3) == 0) ? 16'h0000 :
                              16'($urandom_range(3, 65535));
      endcase
    end else begin
      w.mode       = 1'($urandom_range(0, 1));
      w.frame_len  = 16'($urandom);
      w.hw_type    = 16'($urandom);
      w.ptype      = 16'($urandom);
      w.op_code    = 16'($urandom);
      w.target_ip  = 32'($urandom);
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Checking helpers
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Write all four registers back to back while the block is idle
  task automatic set_config(input logic [31:0] ip, input logic [47:0] mac,
                            input logic [31:0] mask, input logic [31:0] gw);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_OWN_IP;
    cfg_data <= {16'($urandom), ip};
    @(posedge clk_i);
    cfg_idx  <= REG_OWN_MAC;
    cfg_data <= mac;
    @(posedge clk_i);
    cfg_idx  <= REG_SUBNET_MASK;
    cfg_data <= {16'($urandom), mask};
    @(posedge clk_i);
    cfg_idx  <= REG_GATEWAY_IP;
    cfg_data <= {16'($urandom), gw};
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    cfg_own_ip  = ip;
    cfg_own_mac = mac;
    cfg_mask    = mask;
    cfg_gateway = gw;
    setting_count++;
    // Rebuild the address pool: mostly on-subnet, one stray, the gateway
    for (int k = 0; k < POOL_SIZE; k++) ip_pool[k] = (ip & mask) | (32'($urandom) & ~mask);
    ip_pool[POOL_SIZE - 2] = 32'($urandom);
    ip_pool[POOL_SIZE - 1] = gw;
  endtask

  task automatic queue_random(input int unsigned count);
    repeat (count) pending_words.push_back(random_word());
  endtask

  // Hold until every queued word went in and its result came back
  task automatic wait_all_results();
    while (pending_words.size() != 0 || owed_results.size() != 0 || in_bus.valid)
      @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer the next pending word, predict its result on acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid   <= 1'b0;
      in_bus.payload <= '0;
      gap_left       <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        owed_results.push_back(predict_result(in_bus.payload));
        words_sent <= words_sent + 1;
      end
      // Advance only once the current word is gone; otherwise hold it
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left != 0) begin
          in_bus.valid <= 1'b0;
          gap_left     <= gap_left - 1;
        end else if (pending_words.size() != 0) begin
          in_bus.valid   <= 1'b1;
          in_bus.payload <= pending_words.pop_front();
          if (idle_en && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 10);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each result word with the oldest owed one, stall at random
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("result word with nothing owed, action %0d",
                                    out_bus.payload.action));
        end else begin
          want = owed_results.pop_front();
          if (int'(want.action) < 6) action_count[int'(want.action)]++;
          if (out_bus.payload.action !== want.action)
            report_mismatch($sformatf("action got %0d want %0d",
                                      out_bus.payload.action, want.action));
          if (out_bus.payload.out_target_mac !== want.out_target_mac)
            report_mismatch($sformatf("out_target_mac got %h want %h",
                                      out_bus.payload.out_target_mac, want.out_target_mac));
          if (out_bus.payload.out_target_ip !== want.out_target_ip)
            report_mismatch($sformatf("out_target_ip got %h want %h",
                                      out_bus.payload.out_target_ip, want.out_target_ip));
          if (out_bus.payload.resolved_mac !== want.resolved_mac)
            report_mismatch($sformatf("resolved_mac got %h want %h",
                                      out_bus.payload.resolved_mac, want.resolved_mac));
          if (out_bus.payload.next_hop_ip !== want.next_hop_ip)
            report_mismatch($sformatf("next_hop_ip got %h want %h",
                                      out_bus.payload.next_hop_ip, want.next_hop_ip));
        end
      end
      // The long hold-off wins over the random stall bursts
      if (long_hold) begin
        out_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
        out_bus.ready <= 1'b0;
        stall_left    <= stall_left - 1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_bus.ready <= 1'b0;
        stall_left    <= $urandom_range(0, 9);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Hold the output off for a long stretch so the block backs up its input
  initial begin : receiver_hold
    wait (hold_armed);
    @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still owed", cycle_count,
               owed_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [31:0] rand_ip;
    logic [31:0] rand_mask;
    int unsigned prefix;

    // Drive every input to a known value before the first edge
    in_bus.valid   = 1'b0;
    in_bus.payload = '0;
    out_bus.ready  = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_data       = '0;
    idle_en        = 1'b0;
    hold_armed     = 1'b0;
    gap_left       = 0;
    stall_left     = 0;
    fill_slot      = 0;
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      shadow_ip[k]  = '0;
      shadow_mac[k] = '0;
      shadow_vld[k] = 1'b0;
    end
    for (int k = 0; k < 6; k++) action_count[k] = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: a /24 subnet behind a gateway
    set_config(32'hC0A8_0105, 48'h0211_2233_4455, 32'hFFFF_FF00, 32'hC0A8_0101);
    // Reply cases: shortest legal message, one byte too short, longest one, extreme sender fields
    pending_words.push_back(arp_message(MSG_BYTES, HW_ETHERNET, PROTO_IPV4, OPER_REQUEST,
                                        48'hFFFF_FFFF_FFFF, 32'hC0A8_0120, cfg_own_ip));
    pending_words.push_back(arp_message(MSG_BYTES - 16'd1, HW_ETHERNET, PROTO_IPV4,
                                        OPER_REQUEST, 48'h1, 32'h1, cfg_own_ip));
    pending_words.push_back(arp_message(16'hFFFF, HW_ETHERNET, PROTO_IPV4, OPER_REQUEST,
                                        48'h0, 32'h0, cfg_own_ip));
    // Wrong hardware or protocol type, not for us, unknown operations
    pending_words.push_back(arp_message(MSG_BYTES, 16'h0000, PROTO_IPV4, OPER_REQUEST,
                                        48'h5, 32'h5, cfg_own_ip));
    pending_words.push_back(arp_message(MSG_BYTES, 16'hFFFF, PROTO_IPV4, OPER_REPLY,
                                        48'h6, 32'h6, cfg_own_ip));
    pending_words.push_back(arp_message(MSG_BYTES, HW_ETHERNET, 16'h0806, OPER_REPLY,
                                        48'h7, 32'h7, cfg_own_ip));
    pending_words.push_back(arp_message(MSG_BYTES, HW_ETHERNET, PROTO_IPV4, OPER_REQUEST,
                                        48'h8, 32'h8, cfg_own_ip ^ 32'h1));
    pending_words.push_back(arp_message(MSG_BYTES, HW_ETHERNET, PROTO_IPV4, 16'h0000,
                                        48'h9, 32'h9, cfg_own_ip));
    pending_words.push_back(arp_message(MSG_BYTES, HW_ETHERNET, PROTO_IPV4, 16'h0003,
                                        48'hA, 32'hA, cfg_own_ip));
    pending_words.push_back(arp_message(MSG_BYTES, HW_ETHERNET, PROTO_IPV4, 16'hFFFF,
                                        48'hB, 32'hB, cfg_own_ip));
    // Learn a neighbor, see it cached, then resolve it directly
    pending_words.push_back(arp_message(MSG_BYTES, HW_ETHERNET, PROTO_IPV4, OPER_REPLY,
                                        48'h0A0B_0C0D_0E0F, 32'hC0A8_0164, cfg_own_ip));
    pending_words.push_back(arp_message(MSG_BYTES, HW_ETHERNET, PROTO_IPV4, OPER_REPLY,
                                        48'h1111_2222_3333, 32'hC0A8_0164, cfg_own_ip));
    pending_words.push_back(resolve_request(32'hC0A8_0164));
    // Off-subnet: miss on the gateway, learn it, then hit through it
    pending_words.push_back(resolve_request(32'h0A00_0001));
    pending_words.push_back(arp_message(MSG_BYTES, HW_ETHERNET, PROTO_IPV4, OPER_REPLY,
                                        48'h00AA_BBCC_DDEE, 32'hC0A8_0101, cfg_own_ip));
    pending_words.push_back(resolve_request(32'h0808_0808));
    // Fill the rest of the cache, then wrap and evict the first neighbor
    pending_words.push_back(arp_message(MSG_BYTES, HW_ETHERNET, PROTO_IPV4, OPER_REPLY,
                                        48'hFFFF_FFFF_FFFF, 32'h0000_0000, cfg_own_ip));
    pending_words.push_back(arp_message(MSG_BYTES, HW_ETHERNET, PROTO_IPV4, OPER_REPLY,
                                        48'h0, 32'hFFFF_FFFF, cfg_own_ip));
    for (int k = 0; k < 5; k++)
      pending_words.push_back(arp_message(MSG_BYTES, HW_ETHERNET, PROTO_IPV4, OPER_REPLY,
                                          {16'($urandom), 32'($urandom)},
                                          32'hC0A8_0170 + k, cfg_own_ip));
    pending_words.push_back(resolve_request(32'hC0A8_0164));
    pending_words.push_back(resolve_request(32'hFFFF_FFFF));
    wait_all_results();

    // Random traffic with idling; back up the block once, then pause in batches
    idle_en = 1'b1;
    queue_random(120);
    hold_armed = 1'b1;
    wait_all_results();
    repeat (4) begin
      queue_random(45);
      wait_all_results();
    end

    // Zero netmask: everything is local
    set_config(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    pending_words.push_back(resolve_request(32'h0000_0000));
    queue_random(250);
    wait_all_results();

    // Full netmask, all-zero addresses
    set_config(32'h0000_0000, 48'h0, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_random(250);
    wait_all_results();

    // Random prefix lengths; the last stretch runs without idling
    for (int phase = 0; phase < 2; phase++) begin
      prefix    = $urandom_range(0, 32);
      rand_mask = (prefix == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - prefix));
      rand_ip   = 32'($urandom);
      if (phase == 1) idle_en = 1'b0;
      set_config(rand_ip, {16'($urandom), 32'($urandom)}, rand_mask,
                 (rand_ip & rand_mask) | (32'($urandom) & ~rand_mask));
      queue_random((phase == 0) ? 250 : 150);
      wait_all_results();
    end

    // Let any stray result word show up before closing
    repeat (20) @(posedge clk_i);
    if (owed_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", owed_results.size()));

    $display("Ran %0d words over %0d register settings, one %0d-cycle output hold-off.",
             words_sent, setting_count, LONG_HOLD);
    $display("Results: drop %0d reply %0d request %0d hit %0d learned %0d cached %0d",
             action_count[ACT_DROP], action_count[ACT_REPLY], action_count[ACT_REQUEST],
             action_count[ACT_HIT], action_count[ACT_LEARNED], action_count[ACT_CACHED]);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
